// ===== rtl/bpdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpdc_pkg: shared types and constants for the button press classifier
// Holds the register reset values, register indexes, event codes and the
// result record passed from the step logic to the top level.
// ----------------------------------------------------------------------------
package bpdc_pkg;

  // configuration register layout
  localparam int unsigned CFG_BITS      = 16;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned COUNT_BITS_DF = 20;

  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_VERY_LONG = 2'd2;

  // register reset values
  localparam logic [CFG_BITS-1:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [CFG_BITS-1:0] LONG_RST      = 16'd2000;
  localparam logic [CFG_BITS-1:0] VERY_LONG_RST = 16'd4000;

  // release classification codes
  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_SHORT     = 2'd1,
    EV_LONG      = 2'd2,
    EV_VERY_LONG = 2'd3
  } press_event_e;

  // one result item
  typedef struct packed {
    press_event_e press_event;
    logic         press_confirmed;
    logic         stable_level;
    logic         long_zone_cue;
    logic         very_long_zone_cue;
  } result_t;

endpackage

// ===== rtl/bpdc_step.sv =====
// ----------------------------------------------------------------------------
// bpdc_step: per-tick debounce and hold classification
// Combinational next-state and result logic for one raw level sample:
// debounce counter, hold counter, release classification and zone cues.
// ----------------------------------------------------------------------------
module bpdc_step
  import bpdc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DF
) (
  input  logic                  raw_level_i,
  input  logic [CFG_BITS-1:0]   debounce_ticks_i,
  input  logic [CFG_BITS-1:0]   long_ticks_i,
  input  logic [CFG_BITS-1:0]   very_long_ticks_i,
  input  logic                  level_i,
  input  logic                  prev_raw_i,
  input  logic [COUNT_BITS-1:0] unchanged_i,
  input  logic [COUNT_BITS-1:0] hold_i,
  input  logic                  long_given_i,
  input  logic                  very_long_given_i,
  output logic                  level_o,
  output logic [COUNT_BITS-1:0] unchanged_o,
  output logic [COUNT_BITS-1:0] hold_o,
  output logic                  long_given_o,
  output logic                  very_long_given_o,
  output result_t               result_o
);

  localparam int unsigned PAD_BITS = COUNT_BITS - CFG_BITS;

  logic [COUNT_BITS-1:0] deb_ext;
  logic [COUNT_BITS-1:0] long_ext;
  logic [COUNT_BITS-1:0] very_ext;
  logic [COUNT_BITS-1:0] hold_inc;
  logic [COUNT_BITS-1:0] unch_inc;
  logic                  change;

  // thresholds widened to counter width
  assign deb_ext  = {{PAD_BITS{1'b0}}, debounce_ticks_i};
  assign long_ext = {{PAD_BITS{1'b0}}, long_ticks_i};
  assign very_ext = {{PAD_BITS{1'b0}}, very_long_ticks_i};

  // saturating increments
  assign hold_inc = (hold_i == '1) ? hold_i : hold_i + 1'b1;
  assign unch_inc = (unchanged_i == '1) ? unchanged_i : unchanged_i + 1'b1;

  // unchanged counter restarts on any raw edge
  assign unchanged_o = (raw_level_i != prev_raw_i) ? '0 : unch_inc;
  assign change      = (unchanged_o > deb_ext) && (raw_level_i != level_i);
  assign level_o     = change ? raw_level_i : level_i;

  // hold counter, press confirm and release classification
  always_comb begin
    logic [COUNT_BITS-1:0] hold_t;
    logic                  lg_t;
    logic                  vg_t;
    hold_t   = level_i ? hold_i : hold_inc;
    lg_t     = long_given_i;
    vg_t     = very_long_given_i;
    result_o = '{press_event: EV_NONE, press_confirmed: 1'b0, stable_level: level_o,
                 long_zone_cue: 1'b0, very_long_zone_cue: 1'b0};
    if (change) begin
      if (!raw_level_i) begin
        hold_t                   = '0;
        lg_t                     = 1'b0;
        vg_t                     = 1'b0;
        result_o.press_confirmed = 1'b1;
      end else if (hold_t >= very_ext) begin
        result_o.press_event = EV_VERY_LONG;
      end else if (hold_t >= long_ext) begin
        result_o.press_event = EV_LONG;
      end else if (hold_t > deb_ext) begin
        result_o.press_event = EV_SHORT;
      end
    end
    // one-time zone cues while held
    if (!level_o) begin
      if (!lg_t && (hold_t >= long_ext)) begin
        lg_t                   = 1'b1;
        result_o.long_zone_cue = 1'b1;
      end
      if (!vg_t && (hold_t >= very_ext)) begin
        vg_t                        = 1'b1;
        result_o.very_long_zone_cue = 1'b1;
      end
    end
    hold_o            = hold_t;
    long_given_o      = lg_t;
    very_long_given_o = vg_t;
  end

endmodule

// ===== rtl/button_press_duration_classifier.sv =====
// Latency: a result item is valid in the cycle after its sample is accepted.
// Throughput: one sample per cycle; the single result register is refilled
// in the same cycle it is taken, so input stalls only while a result is held.
// Reset: thresholds return to 50 / 2000 / 4000 ticks, the debounced level to
// released, counters and cue flags clear, and no result is pending.
// ----------------------------------------------------------------------------
// button_press_duration_classifier: debounced short / long press detector
// Debounces a raw active-low button level sampled once per tick, times each
// hold, classifies releases and flags entry into the long zones.
// ----------------------------------------------------------------------------
module button_press_duration_classifier
  import bpdc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]     cfg_wdata_i,
  // sample channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    raw_level_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              press_event_o,
  output logic                    press_confirmed_o,
  output logic                    stable_level_o,
  output logic                    long_zone_cue_o,
  output logic                    very_long_zone_cue_o
);

  logic [CFG_BITS-1:0]   debounce_q, long_q, very_long_q;
  logic                  level_q, level_d;
  logic                  prev_raw_q;
  logic [COUNT_BITS-1:0] unchanged_q, unchanged_d;
  logic [COUNT_BITS-1:0] hold_q, hold_d;
  logic                  long_given_q, long_given_d;
  logic                  very_given_q, very_given_d;
  logic                  out_valid_q;
  result_t               result_q, result_d;
  logic                  accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DEBOUNCE_RST;
      long_q      <= LONG_RST;
      very_long_q <= VERY_LONG_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEBOUNCE:  debounce_q  <= cfg_wdata_i;
        REG_LONG:      long_q      <= cfg_wdata_i;
        REG_VERY_LONG: very_long_q <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // handshake: stall only while a result waits and is itself stalled
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  bpdc_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .raw_level_i      (raw_level_i),
    .debounce_ticks_i (debounce_q),
    .long_ticks_i     (long_q),
    .very_long_ticks_i(very_long_q),
    .level_i          (level_q),
    .prev_raw_i       (prev_raw_q),
    .unchanged_i      (unchanged_q),
    .hold_i           (hold_q),
    .long_given_i     (long_given_q),
    .very_long_given_i(very_given_q),
    .level_o          (level_d),
    .unchanged_o      (unchanged_d),
    .hold_o           (hold_d),
    .long_given_o     (long_given_d),
    .very_long_given_o(very_given_d),
    .result_o         (result_d)
  );

  // debounce and hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q      <= 1'b1;
      prev_raw_q   <= 1'b1;
      unchanged_q  <= '0;
      hold_q       <= '0;
      long_given_q <= 1'b0;
      very_given_q <= 1'b0;
    end else if (accept) begin
      level_q      <= level_d;
      prev_raw_q   <= raw_level_i;
      unchanged_q  <= unchanged_d;
      hold_q       <= hold_d;
      long_given_q <= long_given_d;
      very_given_q <= very_given_d;
    end
  end

  // result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign press_event_o        = result_q.press_event;
  assign press_confirmed_o    = result_q.press_confirmed;
  assign stable_level_o       = result_q.stable_level;
  assign long_zone_cue_o      = result_q.long_zone_cue;
  assign very_long_zone_cue_o = result_q.very_long_zone_cue;

`ifndef SYNTHESIS
  // a confirmed press leaves the level pressed
  a_confirm_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && press_confirmed_o) |-> !stable_level_o)
    else $error("press confirmed with released level");

  // a classified release leaves the level released
  a_event_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (press_event_o != EV_NONE)) |-> stable_level_o)
    else $error("release event with pressed level");

  // zone cues only while held
  a_cue_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (long_zone_cue_o || very_long_zone_cue_o)) |-> !stable_level_o)
    else $error("zone cue with released level");

  // the result register mirrors the stored debounced level
  a_level_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (stable_level_o == level_q))
    else $error("result level differs from debounced state");
`endif

endmodule
